[sv/hsh_pkg.sv]
// Package for the HalfSipHash-2-4 stream block: round counts, lane types, round functions.
package hsh_pkg;

  // Round counts of HalfSipHash-2-4
  localparam int COMPRESS_ROUNDS  = 2;
  localparam int FINAL_ROUNDS     = 4;
  // Finalization rounds done per pipeline stage
  localparam int ROUNDS_PER_GROUP = 2;
  localparam int FIN_GROUPS       = (FINAL_ROUNDS + ROUNDS_PER_GROUP - 1) / ROUNDS_PER_GROUP;

  typedef logic [31:0] word_t;
  typedef logic [63:0] key_t;
  typedef logic [7:0]  len_t;
  typedef logic [2:0]  nbytes_t;

  // Lane initialization constants and finalization marker
  localparam word_t INIT_TWO   = 32'h6c796765;
  localparam word_t INIT_THREE = 32'h74656462;
  localparam word_t FIN_MARK   = 32'h000000ff;
  localparam nbytes_t FULL_WORD = 3'd4;

  typedef struct packed {
    word_t v0;
    word_t v1;
    word_t v2;
    word_t v3;
  } lanes_t;

  // Handoff from the compression stage to the finalization pipeline
  typedef struct packed {
    lanes_t lanes;
    word_t  block;
  } fin_item_t;

  function automatic word_t rotl(input word_t x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic lanes_t sip_round(input lanes_t l_in);
    lanes_t l;
    l = l_in;
    l.v0 = l.v0 + l.v1;
    l.v1 = rotl(l.v1, 5) ^ l.v0;
    l.v0 = rotl(l.v0, 16);
    l.v2 = l.v2 + l.v3;
    l.v3 = rotl(l.v3, 8) ^ l.v2;
    l.v0 = l.v0 + l.v3;
    l.v3 = rotl(l.v3, 7) ^ l.v0;
    l.v2 = l.v2 + l.v1;
    l.v1 = rotl(l.v1, 13) ^ l.v2;
    l.v2 = rotl(l.v2, 16);
    return l;
  endfunction

  // Mix one 32-bit block into the lanes
  function automatic lanes_t absorb(input lanes_t l_in, input word_t blk);
    lanes_t l;
    l = l_in;
    l.v3 = l.v3 ^ blk;
    for (int i = 0; i < COMPRESS_ROUNDS; i++) begin
      l = sip_round(l);
    end
    l.v0 = l.v0 ^ blk;
    return l;
  endfunction

  // One stage worth of finalization rounds; the last group may be short
  function automatic lanes_t final_group(input lanes_t l_in, input int g);
    lanes_t l;
    l = l_in;
    for (int i = 0; i < ROUNDS_PER_GROUP; i++) begin
      if (g * ROUNDS_PER_GROUP + i < FINAL_ROUNDS) begin
        l = sip_round(l);
      end
    end
    return l;
  endfunction

endpackage

[sv/hsh_compress.sv]
// Input register, key register and lane state; absorbs one message word per cycle while in_stall is low.
module hsh_compress (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  hsh_pkg::key_t      cfg_hash_key,
  input  logic               in_valid,
  output logic               in_stall,
  input  hsh_pkg::word_t     in_message_word,
  input  hsh_pkg::nbytes_t   in_valid_bytes,
  input  logic               in_last_word,
  output logic               fin_valid,
  input  logic               fin_ready,
  output hsh_pkg::fin_item_t fin_item
);
  import hsh_pkg::*;

  key_t    key_r;
  logic    in_vld_r;
  word_t   word_r;
  nbytes_t vb_r;
  logic    last_r;
  lanes_t  lanes_r;
  len_t    len_r;
  logic    open_r;

  logic    fire;
  nbytes_t vb_sat;
  lanes_t  base_lanes;
  lanes_t  abs_lanes;
  len_t    base_len;
  len_t    fin_len;
  word_t   tail_mask;

  // A last word can only move on when the finalization pipe takes it
  assign fire     = in_vld_r && (!last_r || fin_ready);
  assign in_stall = in_vld_r && !fire;

  // Key register, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid) begin
      key_r <= cfg_hash_key;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_r <= in_message_word;
      vb_r   <= in_valid_bytes;
      last_r <= in_last_word;
    end
  end

  // Compression datapath
  always_comb begin
    vb_sat = (vb_r > FULL_WORD) ? FULL_WORD : vb_r;

    // A new message starts from the key
    if (open_r) begin
      base_lanes = lanes_r;
      base_len   = len_r;
    end else begin
      base_lanes.v0 = key_r[31:0];
      base_lanes.v1 = key_r[63:32];
      base_lanes.v2 = INIT_TWO ^ key_r[31:0];
      base_lanes.v3 = INIT_THREE ^ key_r[63:32];
      base_len      = '0;
    end

    // Full words are absorbed here; a partial last word only feeds the tail block
    if (!last_r || vb_sat == FULL_WORD) begin
      abs_lanes = absorb(base_lanes, word_r);
    end else begin
      abs_lanes = base_lanes;
    end

    case (vb_sat)
      3'd0:    tail_mask = 32'h00000000;
      3'd1:    tail_mask = 32'h000000ff;
      3'd2:    tail_mask = 32'h0000ffff;
      3'd3:    tail_mask = 32'h00ffffff;
      default: tail_mask = 32'h00000000;
    endcase

    fin_len              = base_len + {5'd0, vb_sat};
    fin_item.lanes       = abs_lanes;
    fin_item.block       = {fin_len, 24'd0} | (word_r & tail_mask);
  end

  assign fin_valid = in_vld_r && last_r;

  // Lane state and message bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (fire) begin
      open_r <= !last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      lanes_r <= abs_lanes;
      len_r   <= base_len + 8'd4;
    end
  end

endmodule

[sv/hsh_final.sv]
// Finalization pipeline: tail block absorb, finalization rounds, result register.
module hsh_final (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fin_valid,
  output logic               fin_ready,
  input  hsh_pkg::fin_item_t fin_item,
  output logic               out_valid,
  input  logic               out_stall,
  output hsh_pkg::word_t     out_hash_value
);
  import hsh_pkg::*;

  fin_item_t           st0_r;
  lanes_t              st_lanes_r [1:FIN_GROUPS];
  logic [FIN_GROUPS:0] st_vld_r;
  logic                out_vld_r;
  word_t               hash_r;

  logic [FIN_GROUPS+1:0] st_rdy;
  lanes_t                st_nxt [1:FIN_GROUPS];
  lanes_t                last_lanes;
  word_t                 hash_nxt;

  // Each stage moves when it is empty or its successor moves
  always_comb begin
    st_rdy[FIN_GROUPS+1] = !out_vld_r || !out_stall;
    for (int j = FIN_GROUPS; j >= 0; j--) begin
      st_rdy[j] = !st_vld_r[j] || st_rdy[j+1];
    end
  end

  assign fin_ready = st_rdy[0];

  // Stage datapaths
  always_comb begin
    st_nxt[1]      = absorb(st0_r.lanes, st0_r.block);
    st_nxt[1].v2   = st_nxt[1].v2 ^ FIN_MARK;
    for (int j = 2; j <= FIN_GROUPS; j++) begin
      st_nxt[j] = final_group(st_lanes_r[j-1], j - 2);
    end
    last_lanes = final_group(st_lanes_r[FIN_GROUPS], FIN_GROUPS - 1);
    hash_nxt   = last_lanes.v1 ^ last_lanes.v3;
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (st_rdy[0]) begin
        st_vld_r[0] <= fin_valid;
      end
      for (int j = 1; j <= FIN_GROUPS; j++) begin
        if (st_rdy[j]) begin
          st_vld_r[j] <= st_vld_r[j-1];
        end
      end
      if (st_rdy[FIN_GROUPS+1]) begin
        out_vld_r <= st_vld_r[FIN_GROUPS];
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (st_rdy[0] && fin_valid) begin
      st0_r <= fin_item;
    end
    for (int j = 1; j <= FIN_GROUPS; j++) begin
      if (st_rdy[j] && st_vld_r[j-1]) begin
        st_lanes_r[j] <= st_nxt[j];
      end
    end
    if (st_rdy[FIN_GROUPS+1] && st_vld_r[FIN_GROUPS]) begin
      hash_r <= hash_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_hash_value = hash_r;

endmodule

[sv/halfsiphash_2_4_stream.sv]
// Top level of the keyed HalfSipHash-2-4 message stream hasher.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_hash_key write the 64-bit key (k0 in bits 31:0, k1 in 63:32).
//   cfg_ready is always high. The key is sampled when the first word of a message is
//   absorbed, so write it only while no message is in flight.
//   in_valid/in_stall carry one 32-bit little-endian word per transaction. in_last_word
//   closes the message; in_valid_bytes (0..4, larger values count as 4) applies to it.
//   out_valid/out_stall deliver one 32-bit hash per message, right after its last word.
// Throughput: one word per cycle while in_stall is low, limited by the lane registers,
//   which absorb one word (two SipRounds) per cycle.
// Result path: the last word passes the input register and compression, then a 3-stage
//   finalization pipe and the result register, which holds the hash.
// Reset (rst_n low at a clock edge) empties the pipeline, clears the key and closes
//   any open message.
// Stall: a stalled result holds in the output register; the pipeline keeps taking
//   words until its stages fill, and then raises in_stall only while a last word waits.
module halfsiphash_2_4_stream (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  hsh_pkg::key_t    cfg_hash_key,
  input  logic             in_valid,
  output logic             in_stall,
  input  hsh_pkg::word_t   in_message_word,
  input  hsh_pkg::nbytes_t in_valid_bytes,
  input  logic             in_last_word,
  output logic             out_valid,
  input  logic             out_stall,
  output hsh_pkg::word_t   out_hash_value
);
  import hsh_pkg::*;

  logic      fin_valid;
  logic      fin_ready;
  fin_item_t fin_item;

  assign cfg_ready = 1'b1;

  // Word absorption and lane state
  hsh_compress u_compress (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_hash_key    (cfg_hash_key),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_message_word (in_message_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last_word    (in_last_word),
    .fin_valid       (fin_valid),
    .fin_ready       (fin_ready),
    .fin_item        (fin_item)
  );

  // Finalization and result register
  hsh_final u_final (
    .clk            (clk),
    .rst_n          (rst_n),
    .fin_valid      (fin_valid),
    .fin_ready      (fin_ready),
    .fin_item       (fin_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

`ifndef SYNTH
  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !fin_valid)
    else $error("pipeline not empty after reset");

  // A last word waiting on the finalization pipe keeps its handoff steady
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid && !fin_ready |=> fin_valid && $stable(fin_item))
    else $error("finalization handoff changed while blocked");

  // With an empty output register, back-pressure cannot reach the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");
`endif

endmodule

[tb/tb_halfsiphash_2_4_stream.sv]
// Self-checking testbench for the HalfSipHash-2-4 stream hasher with a built-in hash predictor.
module tb_halfsiphash_2_4_stream;
  import hsh_pkg::*;

  localparam int MAX_WAIT    = 4;     // longest gap or stall drawn per transaction
  localparam int DRAIN_WAIT  = 8;     // settling time after the last expected hash
  localparam int WORD_TARGET = 2000;
  localparam int PHASE_WORDS = 250;

  typedef enum int {HASH_MATCH, HASH_MISMATCH, HASH_UNEXPECTED} hash_check_t;

  // Tracks the keyed lane state per message and queues the hashes it predicts
  class halfsip_tracker_t;
    key_t   key;
    lanes_t lanes;
    len_t   byte_count;
    bit     msg_open;
    word_t  expected_hashes[$];

    function new();
      key        = '0;
      lanes      = '0;
      byte_count = '0;
      msg_open   = 1'b0;
    endfunction

    function word_t rol(word_t x, int unsigned r);
      return (x << r) | (x >> (32 - r));
    endfunction

    function void mix_round();
      lanes.v0 = lanes.v0 + lanes.v1;
      lanes.v1 = rol(lanes.v1, 5) ^ lanes.v0;
      lanes.v0 = rol(lanes.v0, 16);
      lanes.v2 = lanes.v2 + lanes.v3;
      lanes.v3 = rol(lanes.v3, 8) ^ lanes.v2;
      lanes.v0 = lanes.v0 + lanes.v3;
      lanes.v3 = rol(lanes.v3, 7) ^ lanes.v0;
      lanes.v2 = lanes.v2 + lanes.v1;
      lanes.v1 = rol(lanes.v1, 13) ^ lanes.v2;
      lanes.v2 = rol(lanes.v2, 16);
    endfunction

    function void fold_block(word_t blk);
      lanes.v3 = lanes.v3 ^ blk;
      for (int i = 0; i < COMPRESS_ROUNDS; i++) mix_round();
      lanes.v0 = lanes.v0 ^ blk;
    endfunction

    function void set_key(key_t k);
      key = k;
    endfunction

    // Called for every accepted input transaction
    function void note_word(word_t w, nbytes_t nb, logic last);
      nbytes_t n;
      word_t   tail;
      // first word of a message picks up the current key
      if (!msg_open) begin
        lanes.v0   = key[31:0];
        lanes.v1   = key[63:32];
        lanes.v2   = INIT_TWO ^ key[31:0];
        lanes.v3   = INIT_THREE ^ key[63:32];
        byte_count = '0;
        msg_open   = 1'b1;
      end
      if (!last) begin
        fold_block(w);
        byte_count = byte_count + 8'd4;
        return;
      end
      // byte counts past a full word saturate
      n = (nb > FULL_WORD) ? FULL_WORD : nb;
      if (n == FULL_WORD) begin
        fold_block(w);
        tail = '0;
      end else begin
        tail = w & ((32'h1 << (8 * n)) - 32'h1);
      end
      byte_count = byte_count + len_t'(n);
      fold_block({byte_count, tail[23:0]});
      lanes.v2 = lanes.v2 ^ FIN_MARK;
      for (int i = 0; i < FINAL_ROUNDS; i++) mix_round();
      expected_hashes.push_back(lanes.v1 ^ lanes.v3);
      msg_open = 1'b0;
    endfunction

    // Called for every accepted result transaction
    function hash_check_t check_hash(word_t got, output word_t want);
      want = '0;
      if (expected_hashes.size() == 0) return HASH_UNEXPECTED;
      want = expected_hashes.pop_front();
      return (got === want) ? HASH_MATCH : HASH_MISMATCH;
    endfunction

    function int pending();
      return expected_hashes.size();
    endfunction
  endclass

  logic    clk;
  logic    rst_n           = 1'b0;
  logic    cfg_valid       = 1'b0;
  logic    cfg_ready;
  key_t    cfg_hash_key    = '0;
  logic    in_valid        = 1'b0;
  logic    in_stall;
  word_t   in_message_word = '0;
  nbytes_t in_valid_bytes  = '0;
  logic    in_last_word    = 1'b0;
  logic    out_valid;
  logic    out_stall       = 1'b0;
  word_t   out_hash_value;

  halfsip_tracker_t tracker = new();
  int          error_count = 0;
  int          words_sent  = 0;
  bit          in_calm     = 1'b0;
  bit          out_calm    = 1'b0;
  hash_check_t check_status;
  word_t       want_hash;

  halfsiphash_2_4_stream dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_hash_key   (cfg_hash_key),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_message_word(in_message_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last_word   (in_last_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Key write; only called while no message is in flight
  task automatic write_key(key_t k);
    cfg_valid    <= 1'b1;
    cfg_hash_key <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_key(k);
  endtask

  // One input transaction with a random lead-in gap
  task automatic send_word(word_t w, nbytes_t nb, logic last);
    int gap;
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_message_word <= w;
    in_valid_bytes  <= nb;
    in_last_word    <= last;
    do @(posedge clk); while (in_stall);
    tracker.note_word(w, nb, last);
    words_sent++;
  endtask

  // Random words; byte counts on inner words are ignored by the block, so they are random too
  task automatic send_message(int n_words, nbytes_t last_nb);
    for (int i = 0; i < n_words - 1; i++) begin
      send_word($urandom, nbytes_t'($urandom_range(0, 7)), 1'b0);
    end
    send_word($urandom, last_nb, 1'b1);
  endtask

  // Drain all hashes, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic key_t pick_key();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 64'hAAAA_AAAA_AAAA_AAAA;
      3:       return 64'h5555_5555_5555_5555;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Result side: random stall before each result transaction
  initial begin : result_sink
    int hold;
    forever begin
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Compare each result transaction with the oldest predicted hash
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_status = tracker.check_hash(out_hash_value, want_hash);
      if (check_status == HASH_UNEXPECTED) begin
        report($sformatf("hash %08h with none expected", out_hash_value));
      end else if (check_status == HASH_MISMATCH) begin
        report($sformatf("hash_value %08h, expected %08h", out_hash_value, want_hash));
      end
    end
  end

  initial begin : stimulus
    int      phase_start;
    int      n_words;
    int      pick;
    nbytes_t last_nb;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset key of zero first
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);       // empty message, junk bytes ignored
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1);       // tail masking
    send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd3, 1'b1);
    send_word(32'h0000_0000, FULL_WORD, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd5, 1'b1);       // oversize counts saturate
    send_word(32'hFFFF_FFFF, 3'd6, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b0);       // count on inner word ignored
    send_word(32'hFFFF_FFFF, FULL_WORD, 1'b1);
    wait_idle();
    write_key(64'h0706_0504_0302_0100);
    send_word(32'h0302_0100, 3'd0, 1'b0);
    send_word(32'h0706_0504, 3'd7, 1'b0);
    send_word(32'h0B0A_0908, 3'd3, 1'b1);
    send_word(32'h0000_0000, 3'd0, 1'b1);
    wait_idle();
    write_key('1);
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'hFFFF_FFFF, FULL_WORD, 1'b1);
    send_word(32'h8000_0001, 3'd2, 1'b1);
    wait_idle();

    // random phases, a fresh key between them
    while (words_sent < WORD_TARGET) begin
      write_key(pick_key());
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS && words_sent < WORD_TARGET) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) n_words = $urandom_range(60, 80);   // length byte wraps from 64 words up
        else if (pick < 4) n_words = 1;
        else n_words = $urandom_range(2, 8);
        last_nb = ($urandom_range(0, 3) == 0) ? nbytes_t'($urandom_range(5, 7))
                                              : nbytes_t'($urandom_range(0, 4));
        send_message(n_words, last_nb);
      end
      wait_idle();
    end

    if (error_count == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
